/* hw/rtl/cosine_similarity_macros.svh */
// Assertion macros for the cosine similarity block
`ifndef COSINE_SIMILARITY_MACROS_SVH
`define COSINE_SIMILARITY_MACROS_SVH

// Implication checked every cycle outside reset
`define CS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset
`define CS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication checked on every edge, reset included
`define CS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/cs_pkg.sv */
// Shared types and constants of the cosine similarity block
package cs_pkg;
   localparam int FEATURE_BITS = 16;
   localparam int MAX_LEN      = 1024;
   localparam int DOT_W        = 42;
   localparam int NORM_W       = 41;
   localparam int MAG_W        = 42;
   localparam int PROD_W       = 2 * NORM_W;
   localparam int RSQ_W        = 2 * MAG_W - 1;
   localparam int WIDE_W       = 116;
   localparam int MPL_W        = 42;
   localparam int Q_W          = 16;
   localparam int BIT_W        = 4;
   localparam int SCORE_W      = 16;

   typedef enum logic [2:0] {
      ST_ACCUM, ST_CHECK, ST_MUL_P, ST_MUL_R, ST_TRIAL, ST_MUL_L, ST_JUDGE, ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_ACCUM, OP_LOAD_P, OP_LOAD_R, OP_INIT, OP_LOAD_L, OP_STEP, OP_JUDGE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic zero_norm;
      logic last_bit;
      logic out_busy;
   } status_type;
endpackage

/* hw/rtl/cs_ctrl.sv */
// Sequencer for accumulation, norm products and the bitwise ratio search
module cs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  cs_pkg::status_type status,
   output cs_pkg::cmd_type    cmd
);
   cs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cs_pkg::ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = cs_pkg::OP_NONE;
      cmd.emit   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         cs_pkg::ST_ACCUM: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = cs_pkg::OP_ACCUM;
               if (req_tlast) state_in = cs_pkg::ST_CHECK;
            end
         end
         cs_pkg::ST_CHECK: begin
            if (status.zero_norm) begin
               state_in = cs_pkg::ST_EMIT;
            end else begin
               cmd.op   = cs_pkg::OP_LOAD_P;
               state_in = cs_pkg::ST_MUL_P;
            end
         end
         cs_pkg::ST_MUL_P: begin
            if (status.mul_done) begin
               cmd.op   = cs_pkg::OP_LOAD_R;
               state_in = cs_pkg::ST_MUL_R;
            end else begin
               cmd.op = cs_pkg::OP_STEP;
            end
         end
         cs_pkg::ST_MUL_R: begin
            if (status.mul_done) begin
               cmd.op   = cs_pkg::OP_INIT;
               state_in = cs_pkg::ST_TRIAL;
            end else begin
               cmd.op = cs_pkg::OP_STEP;
            end
         end
         cs_pkg::ST_TRIAL: begin
            cmd.op   = cs_pkg::OP_LOAD_L;
            state_in = cs_pkg::ST_MUL_L;
         end
         cs_pkg::ST_MUL_L: begin
            if (status.mul_done) begin
               state_in = cs_pkg::ST_JUDGE;
            end else begin
               cmd.op = cs_pkg::OP_STEP;
            end
         end
         cs_pkg::ST_JUDGE: begin
            cmd.op   = cs_pkg::OP_JUDGE;
            state_in = status.last_bit ? cs_pkg::ST_EMIT : cs_pkg::ST_TRIAL;
         end
         cs_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = cs_pkg::ST_ACCUM;
            end
         end
         default: state_in = cs_pkg::ST_ACCUM;
      endcase
   end
endmodule

/* hw/rtl/cs_datapath.sv */
// Accumulators, shift-add multiplier, ratio search and result register
module cs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  cs_pkg::cmd_type                    cmd,
   output cs_pkg::status_type                 status,
   input  logic signed [cs_pkg::FEATURE_BITS-1:0] elem_a,
   input  logic signed [cs_pkg::FEATURE_BITS-1:0] elem_b,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [cs_pkg::SCORE_W-1:0]         score,
   output logic                               zero_norm
);
   localparam int PW = 2 * cs_pkg::FEATURE_BITS;
   localparam logic [cs_pkg::Q_W-1:0] Q_TOP = cs_pkg::Q_W'(1) << (cs_pkg::Q_W - 1);
   localparam logic [cs_pkg::Q_W-1:0] S_MAX = Q_TOP - cs_pkg::Q_W'(1);

   logic signed [cs_pkg::DOT_W-1:0]  dot_ff;
   logic        [cs_pkg::NORM_W-1:0] na_ff, nb_ff;
   logic        [cs_pkg::WIDE_W-1:0] mcand_ff, prod_ff;
   logic        [cs_pkg::MPL_W-1:0]  mplier_ff;
   logic        [cs_pkg::PROD_W-1:0] p_ff;
   logic        [cs_pkg::RSQ_W-1:0]  r_ff;
   logic        [cs_pkg::Q_W-1:0]    q_ff, trial_ff;
   logic        [cs_pkg::BIT_W-1:0]  bit_ff;
   logic        [cs_pkg::SCORE_W-1:0] score_ff;
   logic                             flag_ff, valid_ff;

   logic signed [PW-1:0]             pab;
   logic        [PW-1:0]             paa, pbb;
   logic signed [cs_pkg::DOT_W:0]    dsum;
   logic        [cs_pkg::NORM_W:0]   nasum, nbsum;
   logic        [cs_pkg::MAG_W-1:0]  mag;
   logic        [cs_pkg::Q_W-1:0]    trial;
   logic        [cs_pkg::Q_W:0]      kval;
   logic        [cs_pkg::WIDE_W-1:0] rhs;
   logic                             pass;
   logic                             zn;

   assign pab   = elem_a * elem_b;
   assign paa   = PW'(elem_a * elem_a);
   assign pbb   = PW'(elem_b * elem_b);
   assign dsum  = (cs_pkg::DOT_W+1)'(dot_ff) + (cs_pkg::DOT_W+1)'(pab);
   assign nasum = (cs_pkg::NORM_W+1)'(na_ff) + (cs_pkg::NORM_W+1)'(paa);
   assign nbsum = (cs_pkg::NORM_W+1)'(nb_ff) + (cs_pkg::NORM_W+1)'(pbb);
   assign mag   = dot_ff[cs_pkg::DOT_W-1] ? cs_pkg::MAG_W'(-dot_ff) : cs_pkg::MAG_W'(dot_ff);
   assign trial = q_ff | (cs_pkg::Q_W'(1) << bit_ff);
   assign kval  = {trial, 1'b0} - (cs_pkg::Q_W+1)'(1);
   assign rhs   = cs_pkg::WIDE_W'({r_ff, 32'b0});
   assign pass  = (prod_ff <= rhs) && (trial_ff <= Q_TOP);
   assign zn    = (na_ff == '0) || (nb_ff == '0);

   assign status.mul_done  = (mplier_ff == '0);
   assign status.zero_norm = zn;
   assign status.last_bit  = (bit_ff == '0);
   assign status.out_busy  = valid_ff && !rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign score      = score_ff;
   assign zero_norm  = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (cmd.emit) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (cmd.op == cs_pkg::OP_ACCUM) begin
         // saturate each accumulator at the limits of its width
         if (dsum[cs_pkg::DOT_W] != dsum[cs_pkg::DOT_W-1])
            dot_ff <= dsum[cs_pkg::DOT_W] ? {1'b1, {(cs_pkg::DOT_W-1){1'b0}}}
                                          : {1'b0, {(cs_pkg::DOT_W-1){1'b1}}};
         else
            dot_ff <= dsum[cs_pkg::DOT_W-1:0];
         na_ff <= nasum[cs_pkg::NORM_W] ? '1 : nasum[cs_pkg::NORM_W-1:0];
         nb_ff <= nbsum[cs_pkg::NORM_W] ? '1 : nbsum[cs_pkg::NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         cs_pkg::OP_LOAD_P: begin
            mcand_ff  <= cs_pkg::WIDE_W'(na_ff);
            mplier_ff <= cs_pkg::MPL_W'(nb_ff);
            prod_ff   <= '0;
         end
         cs_pkg::OP_LOAD_R: begin
            p_ff      <= prod_ff[cs_pkg::PROD_W-1:0];
            mcand_ff  <= cs_pkg::WIDE_W'(mag);
            mplier_ff <= mag;
            prod_ff   <= '0;
         end
         cs_pkg::OP_INIT: begin
            r_ff   <= prod_ff[cs_pkg::RSQ_W-1:0];
            q_ff   <= '0;
            bit_ff <= cs_pkg::BIT_W'(cs_pkg::Q_W - 1);
         end
         cs_pkg::OP_LOAD_L: begin
            trial_ff  <= trial;
            mcand_ff  <= cs_pkg::WIDE_W'(p_ff);
            mplier_ff <= cs_pkg::MPL_W'(kval * kval);
            prod_ff   <= '0;
         end
         cs_pkg::OP_STEP: begin
            if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         cs_pkg::OP_JUDGE: begin
            if (pass) q_ff <= trial_ff;
            bit_ff <= bit_ff - cs_pkg::BIT_W'(1);
         end
         cs_pkg::OP_NONE, cs_pkg::OP_ACCUM: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         flag_ff <= zn;
         priority if (zn)
            score_ff <= '0;
         else if (dot_ff[cs_pkg::DOT_W-1])
            score_ff <= -q_ff;
         else
            score_ff <= (q_ff > S_MAX) ? S_MAX : q_ff;
      end
   end
endmodule

/* hw/rtl/cosine_similarity.sv */
// Cosine similarity of two streamed Q4.12 feature vectors, scored in Q1.15
// Element pairs enter at one per cycle; the item marked tlast closes the vectors. The
// block then leaves the input stalled while one shift-add multiplier, taking one
// multiplier bit per cycle, forms norm_a*norm_b, dot^2 and then sixteen trial products
// of a bitwise search for the rounded ratio (all skipped on a zero norm) before the
// score is ready and the next vector can start. The result waits in an output
// register, so a stalled result side does not hold up the next vector's elements.
`include "cosine_similarity_macros.svh"

module cosine_similarity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] elem_a, [31:16] elem_b
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] score
   output logic        rsp_tuser    // zero_norm
);
   cs_pkg::cmd_type    cmd;
   cs_pkg::status_type status;

   cs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .elem_a     (req_tdata[15:0]),
      .elem_b     (req_tdata[31:16]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .score      (rsp_tdata),
      .zero_norm  (rsp_tuser)
   );

   `CS_ASSERT_IMP(a_zero_score, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 16'h0000, "zero norm with nonzero score")
   `CS_ASSERT_NEXT(a_stall_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input taken during score computation")
   `CS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_tvalid, "result valid straight after reset")
endmodule

/* sim/cosine_similarity_check.sv */
// Checker for the cosine similarity block: predicts each score and compares it
module cosine_similarity_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] elem_a, [31:16] elem_b
   input  logic        req_tlast,   // is_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] score
   input  logic        rsp_tuser,   // zero_norm
   output int          mismatches,
   output int          scores_owed,
   output int          scores_seen
);
   typedef struct {
      logic [cs_pkg::SCORE_W-1:0] score;
      logic                       zero_norm;
   } score_type;

   score_type          score_q[$];
   longint             dot_sum;
   longint unsigned    norm_a_sum;
   longint unsigned    norm_b_sum;

   localparam longint          DOT_HI  = (longint'(1) <<< (cs_pkg::DOT_W - 1)) - 1;
   localparam longint          DOT_LO  = -DOT_HI - 1;
   localparam longint unsigned NORM_HI = (longint'(1) << cs_pkg::NORM_W) - 1;

   // largest q in 0..32768 with (2q-1)^2 * na * nb <= 2^32 * mag^2
   function automatic int unsigned rounded_quotient(longint unsigned mag,
                                                    longint unsigned na,
                                                    longint unsigned nb);
      logic [127:0] rhs;
      logic [127:0] lhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      logic [127:0] k;
      rhs = (128'(mag) * 128'(mag)) << 32;
      lo  = 0;
      hi  = 32768;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         k   = 128'(2 * mid - 1);
         lhs = k * k * 128'(na) * 128'(nb);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic score_type finish_vectors(longint dot, longint unsigned na,
                                                longint unsigned nb);
      score_type       r;
      longint unsigned mag;
      int unsigned     q;
      if (na == 0 || nb == 0) begin
         r.score     = '0;
         r.zero_norm = 1'b1;
      end else begin
         mag = (dot < 0) ? longint'(-dot) : longint'(dot);
         q   = rounded_quotient(mag, na, nb);
         if (dot < 0) r.score = cs_pkg::SCORE_W'(-longint'(q));
         else r.score = (q > 32767) ? cs_pkg::SCORE_W'(32767) : cs_pkg::SCORE_W'(q);
         r.zero_norm = 1'b0;
      end
      return r;
   endfunction

   initial begin
      mismatches  = 0;
      scores_owed = 0;
      scores_seen = 0;
      dot_sum     = 0;
      norm_a_sum  = 0;
      norm_b_sum  = 0;
   end

   always @(posedge clock) begin
      longint          a;
      longint          b;
      longint          d;
      longint unsigned pa;
      longint unsigned pb;
      score_type       want;
      if (reset) begin
         dot_sum    <= 0;
         norm_a_sum <= 0;
         norm_b_sum <= 0;
      end else begin
         // retire the oldest score before queuing a new one
         if (rsp_tvalid && rsp_tready) begin
            scores_seen = scores_seen + 1;
            if (score_q.size() == 0) begin
               $error("unexpected score transfer: score %0d zero_norm %0b",
                      $signed(rsp_tdata), rsp_tuser);
               mismatches = mismatches + 1;
            end else begin
               want = score_q.pop_front();
               if (rsp_tdata !== want.score) begin
                  $error("score: expected %0d, got %0d",
                         $signed(want.score), $signed(rsp_tdata));
                  mismatches = mismatches + 1;
               end
               if (rsp_tuser !== want.zero_norm) begin
                  $error("zero_norm: expected %0b, got %0b", want.zero_norm, rsp_tuser);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            a  = longint'($signed(req_tdata[15:0]));
            b  = longint'($signed(req_tdata[31:16]));
            pa = longint'(a * a);
            pb = longint'(b * b);
            d  = dot_sum + a * b;
            if (d > DOT_HI) d = DOT_HI;
            if (d < DOT_LO) d = DOT_LO;
            pa = (pa > NORM_HI - norm_a_sum) ? NORM_HI : norm_a_sum + pa;
            pb = (pb > NORM_HI - norm_b_sum) ? NORM_HI : norm_b_sum + pb;
            if (req_tlast) begin
               score_q.push_back(finish_vectors(d, pa, pb));
               dot_sum    <= 0;
               norm_a_sum <= 0;
               norm_b_sum <= 0;
            end else begin
               dot_sum    <= d;
               norm_a_sum <= pa;
               norm_b_sum <= pb;
            end
         end
         scores_owed = score_q.size();
      end
   end
endmodule

/* sim/cosine_similarity_test.sv */
// Testbench top for the cosine similarity block: stimulus, handshake pacing, verdict
module cosine_similarity_test;
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   int mismatches;
   int scores_owed;
   int scores_seen;
   int pairs_sent;
   int vectors_sent;
   bit steady;   // no idling on either side while set

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cosine_similarity dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   cosine_similarity_check check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .mismatches(mismatches), .scores_owed(scores_owed), .scores_seen(scores_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
   end

   task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pairs_sent = pairs_sent + 1;
      if (last) vectors_sent = vectors_sent + 1;
   endtask

   task automatic send_repeat(logic [15:0] a, logic [15:0] b, int len);
      for (int i = 0; i < len; i++) send_pair(a, b, i == len - 1);
   endtask

   // random element with extra weight on the extremes and zero
   function automatic logic [15:0] pick_elem();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'(int'($urandom_range(15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_vectors();
      int          len;
      int          shape;
      logic [15:0] a;
      logic [15:0] b;
      len   = ($urandom_range(9) == 0) ? $urandom_range(40) + 1 : $urandom_range(8) + 1;
      shape = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         a = pick_elem();
         case (shape)
            0:       b = a;             // parallel
            1:       b = 16'(-a);       // opposite
            2:       b = 16'h0000;      // zero second vector
            3:       b = a + 16'(int'($urandom_range(63)) - 32);
            default: b = pick_elem();
         endcase
         if (shape == 4) a = 16'h0000;
         send_pair(a, b, i == len - 1);
      end
   endtask

   // drop the request and hold until every score has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scores_owed != 0) @(posedge clock);
   endtask

   initial begin
      pairs_sent   = 0;
      vectors_sent = 0;
      steady       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero norms, parallel and opposite vectors, rounding
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'h1000, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'h8000, 1'b1);
      send_pair(16'h8000, 16'h8000, 1'b1);
      send_pair(16'h7fff, 16'h7fff, 1'b1);
      send_pair(16'h8000, 16'h7fff, 1'b1);
      send_pair(16'h7fff, 16'h8000, 1'b1);
      send_pair(16'hffff, 16'h0001, 1'b1);
      send_pair(16'h1000, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'h1000, 1'b1);
      send_pair(16'h1000, 16'h1000, 1'b0);
      send_pair(16'h1000, 16'h0000, 1'b1);
      send_pair(16'h0003, 16'h0001, 1'b0);
      send_pair(16'h0004, 16'h0002, 1'b0);
      send_pair(16'hfffb, 16'h0007, 1'b1);
      send_pair(16'h5555, 16'haaaa, 1'b0);
      send_pair(16'haaaa, 16'h5555, 1'b1);

      // hold the sender until every score is back
      wait_drained();

      // one vector just past the nominal length with near-full sums
      steady = 1'b1;
      send_repeat(16'h8000, 16'h7fff, 1025);
      steady = 1'b0;

      while (pairs_sent < 1550) begin
         if (pairs_sent > 1200 && pairs_sent < 1400) steady = 1'b1;
         else steady = 1'b0;
         send_random_vectors();
      end
      steady = 1'b0;

      wait_drained();
      repeat (1000) @(posedge clock);
      $display("covered %0d element pairs in %0d vectors, %0d scores checked",
               pairs_sent, vectors_sent, scores_seen);
      $display("including zero norms, an over-long vector and parallel/opposite vectors");
      if (mismatches == 0 && scores_owed == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cs_pkg.sv
hw/rtl/cs_ctrl.sv
hw/rtl/cs_datapath.sv
hw/rtl/cosine_similarity.sv
sim/cosine_similarity_check.sv
sim/cosine_similarity_test.sv
